// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// assertion helpers included by the top rtl file, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// checked only while out of reset
`define PMI_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pmi assertion failed");

// checked at every edge, reset included
`define PMI_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("pmi assertion failed");

`else

`define PMI_ASSERT(label, clk, rst_n, prop)
`define PMI_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ===== hdl/pmi_pkg.sv =====
// ----------------------------------------------------------------------------
// pmi_pkg
// shared types for the palindrome insertion-count block
// ----------------------------------------------------------------------------
package pmi_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_DONE
    } t_state;

    // one table read issued to the memories
    typedef struct packed {
        logic valid;    // read issued this cycle
        logic live;     // a cell completes when the data returns
        logic gap_one;  // first diagonal: previous diagonal reads as zero
        logic gap_two;  // second diagonal: diagonal two back reads as zero
        logic wsel;     // diagonal bank written by this gap
    } t_issue;

    // write back of one cell
    typedef struct packed {
        logic we;
        logic sel;
    } t_wr;

endpackage

// ===== hdl/palindrome_min_insertions_interval_dp.sv =====
// ----------------------------------------------------------------------------
// palindrome_min_insertions_interval_dp
// minimum insertions that turn a byte string into a palindrome
// ----------------------------------------------------------------------------
// the input channel (i_valid / o_ready) takes one byte per item, i_last
// marking the final byte of a string. bytes beyond MAX_LEN are dropped and
// reported through o_overflow. items without i_last give no result.
// the output channel (o_valid / i_ready) carries one result per string.
// bytes are taken one per cycle while idle. after the last byte the interval
// table is swept diagonal by diagonal through two banked diagonal memories,
// one cell per cycle, with a drain state between diagonals; a string of a
// single byte skips the sweep. no byte is accepted during that sweep.
// a finished result waits in the output register while the receiver stalls;
// the next string's bytes are taken meanwhile, but its sweep result holds
// until the register frees. reset returns to idle with an empty string; the
// memories need no clearing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module palindrome_min_insertions_interval_dp #(
    parameter int MAX_LEN = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_symbol,
    input  logic       i_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_insertions,
    output logic       o_overflow
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int DW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);

    pmi_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_len, n_len;
    logic            r_ovf, n_ovf;
    logic [AW-1:0]   r_gap, n_gap;
    logic [AW-1:0]   r_k, n_k;
    logic [DW-1:0]   r_res, n_res;
    logic            r_out_valid, n_out_valid;
    logic [7:0]      r_out_ins, n_out_ins;
    logic            r_out_ovf, n_out_ovf;

    logic            acc;
    logic            room;
    logic [CW-1:0]   len_after;
    logic [CW-1:0]   end_k;
    logic            last_issue;
    logic            last_gap;
    logic            out_free;

    logic            char_we;
    logic [AW-1:0]   char_waddr;
    logic [AW-1:0]   char_raddr_a;
    logic [AW-1:0]   char_raddr_b;
    logic [7:0]      char_a_q;
    logic [7:0]      char_b_q;
    pmi_pkg::t_issue issue;
    logic [AW-1:0]   issue_waddr;
    logic [DW-1:0]   ram0_q;
    logic [DW-1:0]   ram1_q;
    pmi_pkg::t_wr    wr;
    logic [AW-1:0]   wr_addr;
    logic [DW-1:0]   wr_data;

    assign acc        = i_valid && o_ready;
    assign room       = r_len < CW'(MAX_LEN);
    assign len_after  = room ? CW'(r_len + 1'b1) : r_len;
    assign end_k      = CW'(r_len - CW'(r_gap));
    assign last_issue = CW'(r_k) == end_k;
    assign last_gap   = CW'(r_gap) == CW'(r_len - 1'b1);
    assign out_free   = !r_out_valid || i_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pmi_pkg::S_IDLE: begin
                if (acc && i_last) begin
                    n_state = (len_after < CW'(2)) ? pmi_pkg::S_DONE : pmi_pkg::S_RUN;
                end
            end
            pmi_pkg::S_RUN: begin
                if (last_issue) begin
                    n_state = pmi_pkg::S_DRAIN;
                end
            end
            pmi_pkg::S_DRAIN: begin
                n_state = last_gap ? pmi_pkg::S_DONE : pmi_pkg::S_RUN;
            end
            pmi_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = pmi_pkg::S_IDLE;
                end
            end
            default: n_state = pmi_pkg::S_IDLE;
        endcase
    end

    // outputs and memory control
    always_comb begin
        o_ready       = 1'b0;
        char_we       = 1'b0;
        char_waddr    = r_len[AW-1:0];
        // a cell at l = k-1 meets the diagonals read at k
        char_raddr_a  = AW'(r_k - 1'b1);
        char_raddr_b  = AW'(r_k - 1'b1 + r_gap);
        issue         = '0;
        issue.gap_one = r_gap == AW'(1);
        issue.gap_two = r_gap == AW'(2);
        issue.wsel    = r_gap[0];
        issue_waddr   = AW'(r_k - 1'b1);
        case (r_state)
            pmi_pkg::S_IDLE: begin
                o_ready = 1'b1;
                char_we = i_valid && room;
            end
            pmi_pkg::S_RUN: begin
                issue.valid = 1'b1;
                issue.live  = r_k != '0;
            end
            pmi_pkg::S_DRAIN: begin
            end
            pmi_pkg::S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // counters and result
    always_comb begin
        n_len       = r_len;
        n_ovf       = r_ovf;
        n_gap       = r_gap;
        n_k         = r_k;
        n_res       = r_res;
        n_out_valid = r_out_valid && !i_ready;
        n_out_ins   = r_out_ins;
        n_out_ovf   = r_out_ovf;
        case (r_state)
            pmi_pkg::S_IDLE: begin
                if (acc) begin
                    n_len = len_after;
                    n_ovf = r_ovf || !room;
                    n_gap = AW'(1);
                    n_k   = '0;
                    n_res = '0;
                end
            end
            pmi_pkg::S_RUN: begin
                n_k = AW'(r_k + 1'b1);
            end
            pmi_pkg::S_DRAIN: begin
                n_gap = AW'(r_gap + 1'b1);
                n_k   = '0;
                if (last_gap) begin
                    n_res = wr_data;
                end
            end
            pmi_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_ins   = (32'(r_res) > 32'd255) ? 8'hff : 8'(r_res);
                    n_out_ovf   = r_ovf;
                    n_len       = '0;
                    n_ovf       = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pmi_pkg::S_IDLE;
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_gap     <= n_gap;
        r_k       <= n_k;
        r_res     <= n_res;
        r_out_ins <= n_out_ins;
        r_out_ovf <= n_out_ovf;
    end

    assign o_valid      = r_out_valid;
    assign o_insertions = r_out_ins;
    assign o_overflow   = r_out_ovf;

    // two copies of the string let both interval ends be read in the same cycle
    pmi_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_char_a (
        .i_clk   (i_clk),
        .i_we    (char_we),
        .i_waddr (char_waddr),
        .i_wdata (i_symbol),
        .i_raddr (char_raddr_a),
        .o_rdata (char_a_q)
    );

    pmi_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_char_b (
        .i_clk   (i_clk),
        .i_we    (char_we),
        .i_waddr (char_waddr),
        .i_wdata (i_symbol),
        .i_raddr (char_raddr_b),
        .o_rdata (char_b_q)
    );

    // diagonal banks, gap parity picks the one overwritten
    pmi_ram #(.WIDTH(DW), .DEPTH(MAX_LEN)) u_diag0 (
        .i_clk   (i_clk),
        .i_we    (wr.we && !wr.sel),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (r_k),
        .o_rdata (ram0_q)
    );

    pmi_ram #(.WIDTH(DW), .DEPTH(MAX_LEN)) u_diag1 (
        .i_clk   (i_clk),
        .i_we    (wr.we && wr.sel),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (r_k),
        .o_rdata (ram1_q)
    );

    pmi_cell #(.MAX_LEN(MAX_LEN)) u_cell (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_issue  (issue),
        .i_waddr  (issue_waddr),
        .i_char_a (char_a_q),
        .i_char_b (char_b_q),
        .i_ram0_q (ram0_q),
        .i_ram1_q (ram1_q),
        .o_wr     (wr),
        .o_waddr  (wr_addr),
        .o_wdata  (wr_data)
    );

    // write back only follows an issued read
    `PMI_ASSERT(a_wr_in_sweep, i_clk, i_rst_n,
        wr.we |-> (r_state == pmi_pkg::S_RUN || r_state == pmi_pkg::S_DRAIN))
    // the read index never passes the end of the diagonal
    `PMI_ASSERT(a_k_bound, i_clk, i_rst_n,
        (r_state == pmi_pkg::S_RUN) |-> (CW'(r_k) <= end_k))
    // the gap stays inside the stored string
    `PMI_ASSERT(a_gap_bound, i_clk, i_rst_n,
        (r_state == pmi_pkg::S_RUN) |-> (CW'(r_gap) < r_len && r_gap != '0))
    // the drain between diagonals lasts a single cycle
    `PMI_ASSERT(a_drain_once, i_clk, i_rst_n,
        (r_state == pmi_pkg::S_DRAIN) |=> (r_state != pmi_pkg::S_DRAIN))

endmodule

// ===== hdl/pmi_ram.sv =====
// ----------------------------------------------------------------------------
// pmi_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module pmi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/pmi_cell.sv =====
// ----------------------------------------------------------------------------
// pmi_cell
// evaluates one interval cell from the returned memory data
// ----------------------------------------------------------------------------
module pmi_cell #(
    parameter int MAX_LEN = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  pmi_pkg::t_issue            i_issue,
    input  logic [$clog2(MAX_LEN)-1:0] i_waddr,
    input  logic [7:0]                 i_char_a,
    input  logic [7:0]                 i_char_b,
    input  logic [$clog2(MAX_LEN)-1:0] i_ram0_q,
    input  logic [$clog2(MAX_LEN)-1:0] i_ram1_q,
    output pmi_pkg::t_wr               o_wr,
    output logic [$clog2(MAX_LEN)-1:0] o_waddr,
    output logic [$clog2(MAX_LEN)-1:0] o_wdata
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int DW = $clog2(MAX_LEN);

    pmi_pkg::t_issue r_issue;
    logic [AW-1:0]   r_waddr;
    logic [DW-1:0]   r_prev;
    logic [DW-1:0]   newer_q;
    logic [DW-1:0]   older_q;
    logic [DW-1:0]   min_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= '0;
        end else begin
            r_issue <= i_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_waddr <= i_waddr;
        if (r_issue.valid) begin
            r_prev <= newer_q;
        end
    end

    // diagonals not yet written stand for the all-zero start
    always_comb begin
        newer_q = r_issue.gap_one ? '0 : (r_issue.wsel ? i_ram0_q : i_ram1_q);
        older_q = (r_issue.gap_one || r_issue.gap_two) ? '0
                : (r_issue.wsel ? i_ram1_q : i_ram0_q);
        min_q   = (newer_q < r_prev) ? newer_q : r_prev;
        o_wdata = (i_char_a == i_char_b) ? older_q : DW'(min_q + 1'b1);
        o_wr.we  = r_issue.valid && r_issue.live;
        o_wr.sel = r_issue.wsel;
        o_waddr  = r_waddr;
    end

endmodule

// ===== sim/tb_palindrome_min_insertions_interval_dp.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_palindrome_min_insertions_interval_dp
// feeds byte strings into the block and checks every reported insertion count
// and overflow flag against a local interval-table predictor, or against the
// listed values for the fixed rows of a short table of directed strings that
// comes first; then random palindromes, near-palindromes, noise strings and a
// few full-length and too-long strings follow, with random idling on both
// channels
module tb_palindrome_min_insertions_interval_dp;

    localparam int STR_MAX     = 256;
    localparam int ITEM_TARGET = 1900;
    localparam int STALL_LIMIT = 150000;

    typedef struct packed {
        logic [7:0] insertions;
        logic       overflow;
    } t_cost;

    typedef struct {
        logic [7:0] symbol;
        logic       last;
        bit         fixed;
        logic [7:0] insertions;
        logic       overflow;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_symbol = 8'h00;
    logic       i_last = 1'b0;
    logic       i_ready = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_insertions;
    logic       o_overflow;

    // string being collected by the predictor
    logic [7:0]  str_bytes [STR_MAX];
    int unsigned str_len = 0;
    bit          str_dropped = 1'b0;

    t_cost       cost_q [$];
    int          mismatches = 0;
    int unsigned items_sent = 0;
    int unsigned quiet_cycles = 0;
    bit          drv_burst = 1'b0;

    t_row plan [0:19] = '{
        '{8'h00, 1'b1, 1'b1, 8'd0, 1'b0},
        '{8'hFF, 1'b1, 1'b1, 8'd0, 1'b0},
        '{8'h41, 1'b0, 1'b0, 8'd0, 1'b0},
        '{8'h42, 1'b1, 1'b1, 8'd1, 1'b0},
        '{8'h7E, 1'b0, 1'b0, 8'd0, 1'b0},
        '{8'h7E, 1'b1, 1'b1, 8'd0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 8'd0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 8'd0, 1'b0},
        '{8'h00, 1'b1, 1'b1, 8'd0, 1'b0},
        '{8'h61, 1'b0, 1'b0, 8'd0, 1'b0},
        '{8'h62, 1'b0, 1'b0, 8'd0, 1'b0},
        '{8'h63, 1'b1, 1'b1, 8'd2, 1'b0},
        '{8'h80, 1'b0, 1'b0, 8'd0, 1'b0},
        '{8'h01, 1'b0, 1'b0, 8'd0, 1'b0},
        '{8'h80, 1'b0, 1'b0, 8'd0, 1'b0},
        '{8'h7F, 1'b1, 1'b0, 8'd0, 1'b0},
        '{8'h55, 1'b0, 1'b0, 8'd0, 1'b0},
        '{8'hAA, 1'b0, 1'b0, 8'd0, 1'b0},
        '{8'h55, 1'b0, 1'b0, 8'd0, 1'b0},
        '{8'hAA, 1'b1, 1'b0, 8'd0, 1'b0}
    };

    always #6 i_clk = ~i_clk;

    palindrome_min_insertions_interval_dp #(
        .MAX_LEN(STR_MAX)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_symbol    (i_symbol),
        .i_last      (i_last),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_insertions(o_insertions),
        .o_overflow  (o_overflow)
    );

    // interval table over the stored string, two diagonals kept
    function automatic int unsigned min_insertions(int unsigned n);
        int unsigned cur_d [STR_MAX];
        int unsigned alt_d [STR_MAX];
        int unsigned tmp_d [STR_MAX];
        int unsigned v;
        int unsigned g;
        int unsigned l;
        if (n < 2) return 0;
        for (g = 1; g < n; g++) begin
            // alt_d still holds the diagonal two back; cell l reads l+1 before it is rewritten
            for (l = 0; l + g < n; l++) begin
                if (str_bytes[l] == str_bytes[l + g]) begin
                    v = (g >= 2) ? alt_d[l + 1] : 0;
                end else begin
                    v = 1 + ((cur_d[l + 1] < cur_d[l]) ? cur_d[l + 1] : cur_d[l]);
                end
                alt_d[l] = v;
            end
            tmp_d = alt_d;
            alt_d = cur_d;
            cur_d = tmp_d;
        end
        return cur_d[0];
    endfunction

    function automatic bit take_symbol(input logic [7:0] sym, input logic lst,
                                       output t_cost c);
        int unsigned k;
        c = '0;
        if (str_len < STR_MAX) begin
            str_bytes[str_len] = sym;
            str_len++;
        end else begin
            str_dropped = 1'b1;
        end
        if (!lst) return 1'b0;
        k = min_insertions(str_len);
        c.insertions = (k > 255) ? 8'd255 : k[7:0];
        c.overflow   = str_dropped;
        str_len      = 0;
        str_dropped  = 1'b0;
        return 1'b1;
    endfunction

    // mostly short pauses, now and then a long one
    function automatic int unsigned pick_pause();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_byte(input logic [7:0] base, input int unsigned alpha);
        logic [7:0] off;
        if (alpha == 0) return 8'($urandom);
        off = 8'($urandom_range(0, alpha - 1));
        return base + off;
    endfunction

    task automatic send_symbol(input logic [7:0] sym, input logic lst);
        int unsigned pause;
        pause = drv_burst ? 0 : pick_pause();
        if (pause > 0) begin
            i_valid <= 1'b0;
            repeat (pause) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_symbol <= sym;
        i_last   <= lst;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
    endtask

    task automatic send_string(input logic [7:0] word [$]);
        t_cost c;
        int unsigned j;
        for (j = 0; j < word.size(); j++) begin
            send_symbol(word[j], j == word.size() - 1);
            if (take_symbol(word[j], j == word.size() - 1, c)) cost_q.push_back(c);
        end
    endtask

    initial begin : stimulus
        logic [7:0]  word [$];
        logic [7:0]  base;
        logic [7:0]  t;
        t_cost       c;
        int unsigned len;
        int unsigned alpha;
        int unsigned r;
        int unsigned j;
        int unsigned k;
        int unsigned next_long;
        int unsigned long_kind;
        next_long = 250;
        long_kind = 1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            send_symbol(plan[i].symbol, plan[i].last);
            if (take_symbol(plan[i].symbol, plan[i].last, c)) begin
                if (plan[i].fixed) cost_q.push_back({plan[i].insertions, plan[i].overflow});
                else cost_q.push_back(c);
            end
        end

        while (items_sent < ITEM_TARGET) begin
            word.delete();
            drv_burst = ($urandom_range(0, 7) == 0);
            base  = 8'($urandom);
            alpha = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 6);
            if (items_sent >= next_long) begin
                next_long += 450;
                case (long_kind % 3)
                    0: begin
                        // every byte value once: nothing pairs up, worst cost
                        for (j = 0; j < STR_MAX; j++) word.push_back(j[7:0]);
                        for (j = STR_MAX - 1; j > 0; j--) begin
                            k = $urandom_range(0, j);
                            t = word[j];
                            word[j] = word[k];
                            word[k] = t;
                        end
                    end
                    1: begin
                        len = $urandom_range(STR_MAX + 1, STR_MAX + 40);
                        for (j = 0; j < len; j++) word.push_back(pick_byte(base, 4));
                    end
                    default: begin
                        for (j = 0; j < STR_MAX; j++) begin
                            if (j < STR_MAX / 2) word.push_back(pick_byte(base, 3));
                            else word.push_back(word[STR_MAX - 1 - j]);
                        end
                        word[$urandom_range(0, STR_MAX - 1)] = 8'($urandom);
                    end
                endcase
                long_kind++;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    // palindrome, often with a few bytes disturbed
                    len = $urandom_range(1, 24);
                    for (j = 0; j < len; j++) begin
                        if (j < (len + 1) / 2) word.push_back(pick_byte(base, alpha));
                        else word.push_back(word[len - 1 - j]);
                    end
                    if ($urandom_range(0, 9) < 6) begin
                        repeat ($urandom_range(1, 3))
                            word[$urandom_range(0, len - 1)] = pick_byte(base, alpha);
                    end
                end else begin
                    len = $urandom_range(1, 16);
                    for (j = 0; j < len; j++) word.push_back(pick_byte(base, alpha));
                end
            end
            send_string(word);
        end
        i_valid <= 1'b0;

        while (cost_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS palindrome_min_insertions_interval_dp");
        end else begin
            $display("FAIL palindrome_min_insertions_interval_dp");
        end
        $finish;
    end

    initial begin : rx_side
        int unsigned run;
        int unsigned pause;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            // occasional long stretch with the receiver always ready
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
            i_ready <= 1'b1;
            repeat (run) @(posedge i_clk);
            pause = pick_pause();
            if (pause > 0) begin
                i_ready <= 1'b0;
                repeat (pause) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_cost want;
        if (i_rst_n && o_valid && i_ready) begin
            if (cost_q.size() == 0) begin
                $error("unexpected result: o_insertions %0d o_overflow %0d",
                       o_insertions, o_overflow);
                mismatches++;
            end else begin
                want = cost_q.pop_front();
                if (o_insertions !== want.insertions) begin
                    $error("o_insertions expected %0d actual %0d", want.insertions, o_insertions);
                    mismatches++;
                end
                if (o_overflow !== want.overflow) begin
                    $error("o_overflow expected %0d actual %0d", want.overflow, o_overflow);
                    mismatches++;
                end
            end
        end
    end

    // no item moves during a full-length sweep; the stall limit allows for it
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL palindrome_min_insertions_interval_dp");
            $finish;
        end
    end

endmodule
